/* design/lobm_pkg.sv */
package lobm_pkg;

  // Order kind codes
  typedef enum logic [1:0] {
    KIND_MARKET = 2'd0,
    KIND_LIMIT  = 2'd1,
    KIND_REST   = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_e;

  // Order side codes
  typedef enum logic {
    SIDE_BUY  = 1'b0,
    SIDE_SELL = 1'b1
  } side_e;

  // Result status codes
  typedef enum logic {
    STATUS_DONE = 1'b0,
    STATUS_FULL = 1'b1
  } status_e;

  // Write strobes into one side of the book
  typedef struct packed {
    logic lvl;
    logic qty;
  } mem_we_t;

  // Commands to the fill arithmetic unit
  typedef struct packed {
    logic load;
    logic step;
    logic mul;
    logic acc;
  } fill_ctl_t;

  // Flags back from the fill arithmetic unit
  typedef struct packed {
    logic rem_zero;
    logic full;
  } fill_sts_t;

endpackage

/* design/lobm_side_mem.sv */
module lobm_side_mem #(
  parameter int PRICE_LEVELS     = 256,
  parameter int ORDERS_PER_LEVEL = 16,
  parameter int QUANTITY_BITS    = 16
) (
  input  logic                                              clk_i,
  input  lobm_pkg::mem_we_t                                 we_i,
  input  logic [$clog2(PRICE_LEVELS)-1:0]                   lvl_addr_i,
  input  logic [$clog2(ORDERS_PER_LEVEL+1)-1:0]             cnt_wdata_i,
  input  logic [$clog2(ORDERS_PER_LEVEL)-1:0]               head_wdata_i,
  input  logic [$clog2(PRICE_LEVELS*ORDERS_PER_LEVEL)-1:0]  qty_addr_i,
  input  logic [QUANTITY_BITS-1:0]                          qty_wdata_i,
  output logic [$clog2(ORDERS_PER_LEVEL+1)-1:0]             cnt_rdata_o,
  output logic [$clog2(ORDERS_PER_LEVEL)-1:0]               head_rdata_o,
  output logic [QUANTITY_BITS-1:0]                          qty_rdata_o
);

  localparam int CW    = $clog2(ORDERS_PER_LEVEL + 1);
  localparam int HW    = $clog2(ORDERS_PER_LEVEL);
  localparam int SLOTS = PRICE_LEVELS * ORDERS_PER_LEVEL;

  logic [CW-1:0]            cnt_mem  [PRICE_LEVELS];
  logic [HW-1:0]            head_mem [PRICE_LEVELS];
  logic [QUANTITY_BITS-1:0] qty_mem  [SLOTS];

  // Level table: count and head slot per price level
  always_ff @(posedge clk_i) begin
    if (we_i.lvl) begin
      cnt_mem[lvl_addr_i]  <= cnt_wdata_i;
      head_mem[lvl_addr_i] <= head_wdata_i;
    end
    cnt_rdata_o  <= cnt_mem[lvl_addr_i];
    head_rdata_o <= head_mem[lvl_addr_i];
  end

  // Resting order quantities, one FIFO ring per level
  always_ff @(posedge clk_i) begin
    if (we_i.qty) begin
      qty_mem[qty_addr_i] <= qty_wdata_i;
    end
    qty_rdata_o <= qty_mem[qty_addr_i];
  end

endmodule

/* design/lobm_fill_unit.sv */
module lobm_fill_unit #(
  parameter int QUANTITY_BITS = 16,
  parameter int LEVEL_BITS    = 8
) (
  input  logic                                clk_i,
  input  lobm_pkg::fill_ctl_t                 ctl_i,
  input  logic [QUANTITY_BITS-1:0]            rem_init_i,
  input  logic [QUANTITY_BITS-1:0]            qty_i,
  input  logic [LEVEL_BITS-1:0]               lvl_i,
  output logic [QUANTITY_BITS-1:0]            rem_o,
  output logic [QUANTITY_BITS-1:0]            filled_o,
  output logic [QUANTITY_BITS+LEVEL_BITS-1:0] value_o,
  output logic [QUANTITY_BITS-1:0]            qty_left_o,
  output lobm_pkg::fill_sts_t                 sts_o
);

  localparam int VW = QUANTITY_BITS + LEVEL_BITS;

  logic [QUANTITY_BITS-1:0] rem_q, filled_q, take_q, take;
  logic [VW-1:0]            value_q, prod_q;

  // Take the whole resting order or what is left of the incoming one
  assign sts_o.full     = (qty_i <= rem_q);
  assign sts_o.rem_zero = (rem_q == '0);
  assign take           = sts_o.full ? qty_i : rem_q;
  assign qty_left_o     = qty_i - rem_q;

  // Running remainder, fill and value, with the product registered first
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      rem_q    <= rem_init_i;
      filled_q <= '0;
      value_q  <= '0;
    end else begin
      if (ctl_i.step) begin
        take_q   <= take;
        rem_q    <= rem_q - take;
        filled_q <= filled_q + take;
      end
      if (ctl_i.mul) begin
        prod_q <= VW'(take_q) * VW'(lvl_i);
      end
      if (ctl_i.acc) begin
        value_q <= value_q + prod_q;
      end
    end
  end

  assign rem_o    = rem_q;
  assign filled_o = filled_q;
  assign value_o  = value_q;

endmodule

/* design/limit_order_book_matcher_top.sv */
// An ignored order goes straight to its result. Otherwise each level visited
// is read and checked (S_LRD, S_LVL), each resting order hit is read, filled,
// multiplied and accumulated (S_QRD, S_QTY, S_MUL, S_ACC), and a remainder is
// rested (S_RRD, S_RWR). One order at a time; the next is accepted once its
// result is registered. Reset: asynchronous, active low; a clearing pass then
// empties every level, with in_ready_o low until it ends.
module limit_order_book_matcher_top #(
  parameter int PRICE_LEVELS     = 256,
  parameter int ORDERS_PER_LEVEL = 16,
  parameter int QUANTITY_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic        side_i,
  input  logic [15:0] quantity_i,
  input  logic [7:0]  price_tick_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic [15:0] fill_units_o,
  output logic [23:0] fill_value_o,
  output logic [15:0] rested_quantity_o,
  output logic [7:0]  best_bid_o,
  output logic        bid_present_o,
  output logic [7:0]  best_ask_o,
  output logic        ask_present_o
);

  localparam int LW   = $clog2(PRICE_LEVELS);
  localparam int HW   = $clog2(ORDERS_PER_LEVEL);
  localparam int CW   = $clog2(ORDERS_PER_LEVEL + 1);
  localparam int SW   = CW + 1;
  localparam int QAW  = $clog2(PRICE_LEVELS * ORDERS_PER_LEVEL);
  localparam int QB   = QUANTITY_BITS;
  localparam int VW   = QB + LW;
  localparam int CMPW = ((LW > 8) ? LW : 8) + 1;
  localparam int QXW  = (QB > 16) ? QB : 16;
  localparam int VXW  = (VW > 24) ? VW : 24;
  localparam int LXW  = (LW > 8) ? LW : 8;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_LRD   = 11'b00000000100,
    S_LVL   = 11'b00000001000,
    S_QRD   = 11'b00000010000,
    S_QTY   = 11'b00000100000,
    S_MUL   = 11'b00001000000,
    S_ACC   = 11'b00010000000,
    S_RRD   = 11'b00100000000,
    S_RWR   = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_e;

  state_e st_q, st_d;

  logic [LW-1:0]   lv_q, lv_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [HW-1:0]   head_q, head_d;
  logic [1:0]      kind_q, kind_d;
  logic            side_q, side_d;
  logic [CMPW-1:0] tick_q, tick_d;
  logic            status_q, status_d;
  logic [QB-1:0]   rested_q, rested_d;
  logic [LW-1:0]   bb_q, bb_d, ba_q, ba_d;
  logic            bbv_q, bbv_d, bav_q, bav_d;
  logic            out_valid_q, out_valid_d;
  logic            out_load;

  logic            out_status_q;
  logic [15:0]     out_units_q, out_rested_q;
  logic [23:0]     out_value_q;
  logic [7:0]      out_bb_q, out_ba_q;
  logic            out_bbv_q, out_bav_q;

  // Input fields brought to internal widths
  logic [QXW-1:0]  qty_x;
  logic [QB-1:0]   qty_in;
  logic [CMPW-1:0] tick_in;
  logic            act;

  assign qty_x   = QXW'(quantity_i);
  assign qty_in  = qty_x[QB-1:0];
  assign tick_in = CMPW'(price_tick_i);
  assign act     = (kind_i != lobm_pkg::KIND_UNUSED) && (qty_in != '0) &&
                   ((kind_i == lobm_pkg::KIND_MARKET) ||
                    (tick_in < CMPW'(PRICE_LEVELS)));

  // Book memories, one per side, sharing address and data
  lobm_pkg::mem_we_t        we_bid, we_ask;
  logic [CW-1:0]            cnt_wdata, cnt_bid, cnt_ask, cnt_rd;
  logic [HW-1:0]            head_wdata, head_bid, head_ask, head_rd;
  logic [QAW-1:0]           qty_addr;
  logic [QB-1:0]            qty_wdata, qty_bid, qty_ask, qty_rd;
  logic [HW-1:0]            slot;
  logic [SW-1:0]            slot_sum;
  logic [HW-1:0]            rest_slot;
  logic [HW-1:0]            head_next;
  lobm_pkg::mem_we_t        we_sel;
  logic                     use_ask;

  lobm_side_mem #(
    .PRICE_LEVELS    (PRICE_LEVELS),
    .ORDERS_PER_LEVEL(ORDERS_PER_LEVEL),
    .QUANTITY_BITS   (QUANTITY_BITS)
  ) u_bid_mem (
    .clk_i       (clk_i),
    .we_i        (we_bid),
    .lvl_addr_i  (lv_q),
    .cnt_wdata_i (cnt_wdata),
    .head_wdata_i(head_wdata),
    .qty_addr_i  (qty_addr),
    .qty_wdata_i (qty_wdata),
    .cnt_rdata_o (cnt_bid),
    .head_rdata_o(head_bid),
    .qty_rdata_o (qty_bid)
  );

  lobm_side_mem #(
    .PRICE_LEVELS    (PRICE_LEVELS),
    .ORDERS_PER_LEVEL(ORDERS_PER_LEVEL),
    .QUANTITY_BITS   (QUANTITY_BITS)
  ) u_ask_mem (
    .clk_i       (clk_i),
    .we_i        (we_ask),
    .lvl_addr_i  (lv_q),
    .cnt_wdata_i (cnt_wdata),
    .head_wdata_i(head_wdata),
    .qty_addr_i  (qty_addr),
    .qty_wdata_i (qty_wdata),
    .cnt_rdata_o (cnt_ask),
    .head_rdata_o(head_ask),
    .qty_rdata_o (qty_ask)
  );

  // Resting phases use the own side, matching phases the opposite side
  assign use_ask = ((st_q == S_RRD) || (st_q == S_RWR)) ? side_q : ~side_q;
  assign cnt_rd  = use_ask ? cnt_ask : cnt_bid;
  assign head_rd = use_ask ? head_ask : head_bid;
  assign qty_rd  = use_ask ? qty_ask : qty_bid;

  always_comb begin
    we_bid = '0;
    we_ask = '0;
    if (st_q == S_CLEAR) begin
      we_bid = we_sel;
      we_ask = we_sel;
    end else if (use_ask) begin
      we_ask = we_sel;
    end else begin
      we_bid = we_sel;
    end
  end

  // Slot arithmetic: ring wrap by one compare and subtract
  assign slot_sum  = SW'(head_rd) + SW'(cnt_rd);
  assign rest_slot = (slot_sum >= SW'(ORDERS_PER_LEVEL)) ?
                     HW'(slot_sum - SW'(ORDERS_PER_LEVEL)) : HW'(slot_sum);
  assign head_next = (head_q == HW'(ORDERS_PER_LEVEL - 1)) ? '0 : head_q + 1'b1;
  assign slot      = (st_q == S_RWR) ? rest_slot : head_q;
  assign qty_addr  = QAW'(lv_q) * QAW'(ORDERS_PER_LEVEL) + QAW'(slot);

  // Shared fill unit
  lobm_pkg::fill_ctl_t fctl;
  lobm_pkg::fill_sts_t fsts;
  logic [QB-1:0]       rem, filled, qty_left;
  logic [VW-1:0]       value;

  lobm_fill_unit #(
    .QUANTITY_BITS(QUANTITY_BITS),
    .LEVEL_BITS   (LW)
  ) u_fill (
    .clk_i     (clk_i),
    .ctl_i     (fctl),
    .rem_init_i(qty_in),
    .qty_i     (qty_rd),
    .lvl_i     (lv_q),
    .rem_o     (rem),
    .filled_o  (filled),
    .value_o   (value),
    .qty_left_o(qty_left),
    .sts_o     (fsts)
  );

  // Level within the limit price of the order
  function automatic logic within_limit(logic [LW-1:0] lv, logic [CMPW-1:0] tk,
                                        logic sd, logic lim);
    logic [CMPW-1:0] lx;
    lx = CMPW'(lv);
    if (!lim) begin
      within_limit = 1'b1;
    end else if (sd == lobm_pkg::SIDE_BUY) begin
      within_limit = (lx <= tk);
    end else begin
      within_limit = (lx >= tk);
    end
  endfunction

  logic          opp_valid_in;
  logic [LW-1:0] opp_lv_in;
  logic          last_lv;
  logic [LW-1:0] step_lv;
  logic          lim_ord;

  assign opp_valid_in = (side_i == lobm_pkg::SIDE_BUY) ? bav_q : bbv_q;
  assign opp_lv_in    = (side_i == lobm_pkg::SIDE_BUY) ? ba_q : bb_q;
  assign last_lv      = (side_q == lobm_pkg::SIDE_BUY) ?
                        (lv_q == LW'(PRICE_LEVELS - 1)) : (lv_q == '0);
  assign step_lv      = (side_q == lobm_pkg::SIDE_BUY) ? lv_q + 1'b1 : lv_q - 1'b1;
  assign lim_ord      = (kind_q == lobm_pkg::KIND_LIMIT);

  // Sequencer
  always_comb begin
    st_d       = st_q;
    lv_d       = lv_q;
    cnt_d      = cnt_q;
    head_d     = head_q;
    kind_d     = kind_q;
    side_d     = side_q;
    tick_d     = tick_q;
    status_d   = status_q;
    rested_d   = rested_q;
    bb_d       = bb_q;
    bbv_d      = bbv_q;
    ba_d       = ba_q;
    bav_d      = bav_q;
    we_sel     = '0;
    cnt_wdata  = cnt_q;
    head_wdata = head_q;
    qty_wdata  = qty_left;
    fctl       = '0;
    out_load   = 1'b0;

    unique case (st_q)
      S_CLEAR: begin
        we_sel.lvl = 1'b1;
        cnt_wdata  = '0;
        head_wdata = '0;
        if (lv_q == LW'(PRICE_LEVELS - 1)) begin
          lv_d = '0;
          st_d = S_IDLE;
        end else begin
          lv_d = lv_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d    = kind_i;
          side_d    = side_i;
          tick_d    = tick_in;
          status_d  = lobm_pkg::STATUS_DONE;
          rested_d  = '0;
          fctl.load = 1'b1;
          if (!act) begin
            st_d = S_DONE;
          end else if (kind_i == lobm_pkg::KIND_REST) begin
            lv_d = tick_in[LW-1:0];
            st_d = S_RRD;
          end else if (opp_valid_in &&
                       within_limit(opp_lv_in, tick_in, side_i,
                                    kind_i == lobm_pkg::KIND_LIMIT)) begin
            lv_d = opp_lv_in;
            st_d = S_LRD;
          end else if (kind_i == lobm_pkg::KIND_LIMIT) begin
            lv_d = tick_in[LW-1:0];
            st_d = S_RRD;
          end else begin
            st_d = S_DONE;
          end
        end
      end
      S_LRD: begin
        st_d = S_LVL;
      end
      S_LVL: begin
        priority if (cnt_rd != '0 && !fsts.rem_zero &&
                     within_limit(lv_q, tick_q, side_q, lim_ord)) begin
          cnt_d  = cnt_rd;
          head_d = head_rd;
          st_d   = S_QRD;
        end else if (cnt_rd != '0) begin
          // level still holds orders: it is the new best
          if (side_q == lobm_pkg::SIDE_BUY) begin
            ba_d  = lv_q;
            bav_d = 1'b1;
          end else begin
            bb_d  = lv_q;
            bbv_d = 1'b1;
          end
          st_d = (lim_ord && !fsts.rem_zero) ? S_RRD : S_DONE;
          lv_d = (lim_ord && !fsts.rem_zero) ? tick_q[LW-1:0] : lv_q;
        end else if (last_lv) begin
          if (side_q == lobm_pkg::SIDE_BUY) begin
            ba_d  = '0;
            bav_d = 1'b0;
          end else begin
            bb_d  = '0;
            bbv_d = 1'b0;
          end
          st_d = (lim_ord && !fsts.rem_zero) ? S_RRD : S_DONE;
          lv_d = (lim_ord && !fsts.rem_zero) ? tick_q[LW-1:0] : lv_q;
        end else begin
          lv_d = step_lv;
          st_d = S_LRD;
        end
      end
      S_QRD: begin
        st_d = S_QTY;
      end
      S_QTY: begin
        fctl.step = 1'b1;
        if (!fsts.full) begin
          // partial fill: keep the rest of the resting order
          we_sel.qty = 1'b1;
          qty_wdata  = qty_left;
        end else begin
          // resting order consumed: pop it from the level
          we_sel.lvl = 1'b1;
          cnt_wdata  = cnt_q - 1'b1;
          head_wdata = head_next;
          cnt_d      = cnt_q - 1'b1;
          head_d     = head_next;
        end
        st_d = S_MUL;
      end
      S_MUL: begin
        fctl.mul = 1'b1;
        st_d     = S_ACC;
      end
      S_ACC: begin
        fctl.acc = 1'b1;
        priority if (cnt_q == '0 && !last_lv) begin
          lv_d = step_lv;
          st_d = S_LRD;
        end else if (cnt_q == '0) begin
          if (side_q == lobm_pkg::SIDE_BUY) begin
            ba_d  = '0;
            bav_d = 1'b0;
          end else begin
            bb_d  = '0;
            bbv_d = 1'b0;
          end
          st_d = (lim_ord && !fsts.rem_zero) ? S_RRD : S_DONE;
          lv_d = (lim_ord && !fsts.rem_zero) ? tick_q[LW-1:0] : lv_q;
        end else if (!fsts.rem_zero) begin
          st_d = S_QRD;
        end else begin
          if (side_q == lobm_pkg::SIDE_BUY) begin
            ba_d  = lv_q;
            bav_d = 1'b1;
          end else begin
            bb_d  = lv_q;
            bbv_d = 1'b1;
          end
          st_d = S_DONE;
        end
      end
      S_RRD: begin
        st_d = S_RWR;
      end
      S_RWR: begin
        if (cnt_rd < CW'(ORDERS_PER_LEVEL)) begin
          we_sel.qty = 1'b1;
          we_sel.lvl = 1'b1;
          qty_wdata  = rem;
          cnt_wdata  = cnt_rd + 1'b1;
          head_wdata = head_rd;
          rested_d   = rem;
          if (side_q == lobm_pkg::SIDE_BUY) begin
            if (!bbv_q || lv_q > bb_q) begin
              bb_d  = lv_q;
              bbv_d = 1'b1;
            end
          end else begin
            if (!bav_q || lv_q < ba_q) begin
              ba_d  = lv_q;
              bav_d = 1'b1;
            end
          end
        end else begin
          status_d = lobm_pkg::STATUS_FULL;
        end
        st_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          st_d     = S_IDLE;
        end
      end
      default: begin
        st_d = S_CLEAR;
        lv_d = '0;
      end
    endcase
  end

  // Output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_CLEAR;
      lv_q        <= '0;
      bb_q        <= '0;
      bbv_q       <= 1'b0;
      ba_q        <= '0;
      bav_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      lv_q        <= lv_d;
      bb_q        <= bb_d;
      bbv_q       <= bbv_d;
      ba_q        <= ba_d;
      bav_q       <= bav_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result fields with saturation
  logic [QXW-1:0] filled_x, rested_x;
  logic [VXW-1:0] value_x;
  logic [LXW-1:0] bb_x, ba_x;

  assign filled_x = QXW'(filled);
  assign rested_x = QXW'(rested_q);
  assign value_x  = VXW'(value);
  assign bb_x     = LXW'(bb_q);
  assign ba_x     = LXW'(ba_q);

  // Order payload and result registers
  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    head_q   <= head_d;
    kind_q   <= kind_d;
    side_q   <= side_d;
    tick_q   <= tick_d;
    status_q <= status_d;
    rested_q <= rested_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_units_q  <= (filled_x > QXW'(16'hFFFF)) ? 16'hFFFF : filled_x[15:0];
      out_value_q  <= (value_x > VXW'(24'hFFFFFF)) ? 24'hFFFFFF : value_x[23:0];
      out_rested_q <= rested_x[15:0];
      out_bb_q     <= bbv_q ? bb_x[7:0] : 8'd0;
      out_bbv_q    <= bbv_q;
      out_ba_q     <= bav_q ? ba_x[7:0] : 8'd0;
      out_bav_q    <= bav_q;
    end
  end

  assign in_ready_o        = (st_q == S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign fill_units_o      = out_units_q;
  assign fill_value_o      = out_value_q;
  assign rested_quantity_o = out_rested_q;
  assign best_bid_o        = out_bb_q;
  assign bid_present_o     = out_bbv_q;
  assign best_ask_o        = out_ba_q;
  assign ask_present_o     = out_bav_q;

endmodule

/* design/lobm_checker.sv */
module lobm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        status_o,
  input logic [15:0] rested_quantity_o,
  input logic [7:0]  best_bid_o,
  input logic        bid_present_o,
  input logic [7:0]  best_ask_o,
  input logic        ask_present_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rested_quantity_o))
    else $error("result changed while stalled");

  // Report an empty bid side as tick zero
  a_bid_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bid_present_o |-> best_bid_o == 8'd0)
    else $error("empty bid side with nonzero tick");

  // Report an empty ask side as tick zero
  a_ask_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ask_present_o |-> best_ask_o == 8'd0)
    else $error("empty ask side with nonzero tick");

  // Drop the remainder when the level is full
  a_full_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> rested_quantity_o == 16'd0)
    else $error("full level still rested quantity");

endmodule

bind limit_order_book_matcher_top lobm_checker u_lobm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .status_o         (status_o),
  .rested_quantity_o(rested_quantity_o),
  .best_bid_o       (best_bid_o),
  .bid_present_o    (bid_present_o),
  .best_ask_o       (best_ask_o),
  .ask_present_o    (ask_present_o)
);

/* test/limit_order_book_matcher_top_test.sv */
`timescale 1ns / 100ps

module limit_order_book_matcher_top_test;

  localparam int NUM_LEVELS = 256;
  localparam int LEVEL_DEPTH = 16;
  localparam int BOOK_BID = 0;
  localparam int BOOK_ASK = 1;

  typedef struct packed {
    logic        status;
    logic [15:0] fill_units;
    logic [23:0] fill_value;
    logic [15:0] rested_quantity;
    logic [7:0]  best_bid;
    logic        bid_present;
    logic [7:0]  best_ask;
    logic        ask_present;
  } fill_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i = '0;
  logic        side_i = 1'b0;
  logic [15:0] quantity_i = '0;
  logic [7:0]  price_tick_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        status_o;
  logic [15:0] fill_units_o;
  logic [23:0] fill_value_o;
  logic [15:0] rested_quantity_o;
  logic [7:0]  best_bid_o;
  logic        bid_present_o;
  logic [7:0]  best_ask_o;
  logic        ask_present_o;

  // Book mirror: index 0 bids, 1 asks
  logic [15:0] order_qty [2][NUM_LEVELS][LEVEL_DEPTH];
  int          level_head [2][NUM_LEVELS];
  int          level_count [2][NUM_LEVELS];
  fill_report_t expected_reports [$];
  int          error_count = 0;
  int          hold_off_cycles = 0;

  limit_order_book_matcher_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .side_i, .quantity_i,
    .price_tick_i, .out_valid_o, .out_ready_i, .status_o, .fill_units_o,
    .fill_value_o, .rested_quantity_o, .best_bid_o, .bid_present_o,
    .best_ask_o, .ask_present_o
  );

  always #5 clk_i = ~clk_i;

  // Predict the report of one order and update the book mirror
  function automatic fill_report_t match_order(logic [1:0] kind, logic side,
                                               logic [15:0] qty, logic [7:0] tick);
    fill_report_t rpt;
    int          remain, lv, n, h, rest_book, hit_book, slot;
    longint      filled, value;
    rpt = '0;
    remain = qty;
    filled = 0;
    value = 0;
    if (kind != lobm_pkg::KIND_UNUSED && qty != 0) begin
      rest_book = (side == lobm_pkg::SIDE_BUY) ? BOOK_BID : BOOK_ASK;
      hit_book = (side == lobm_pkg::SIDE_BUY) ? BOOK_ASK : BOOK_BID;
      // Walk opposite levels best first
      if (kind != lobm_pkg::KIND_REST) begin
        for (n = 0; n < NUM_LEVELS && remain > 0; n++) begin
          lv = (side == lobm_pkg::SIDE_BUY) ? n : NUM_LEVELS - 1 - n;
          if (kind == lobm_pkg::KIND_LIMIT && side == lobm_pkg::SIDE_BUY && lv > tick) break;
          if (kind == lobm_pkg::KIND_LIMIT && side == lobm_pkg::SIDE_SELL && lv < tick) break;
          while (level_count[hit_book][lv] > 0 && remain > 0) begin
            h = level_head[hit_book][lv];
            if (order_qty[hit_book][lv][h] > remain) begin
              filled += remain;
              value += longint'(remain) * lv;
              order_qty[hit_book][lv][h] = 16'(order_qty[hit_book][lv][h] - remain);
              remain = 0;
            end else begin
              filled += order_qty[hit_book][lv][h];
              value += longint'(order_qty[hit_book][lv][h]) * lv;
              remain -= order_qty[hit_book][lv][h];
              level_head[hit_book][lv] = (h + 1) % LEVEL_DEPTH;
              level_count[hit_book][lv]--;
            end
          end
        end
      end
      // Rest the remainder, or flag a full level
      if (kind != lobm_pkg::KIND_MARKET && remain > 0) begin
        if (level_count[rest_book][tick] < LEVEL_DEPTH) begin
          slot = (level_head[rest_book][tick] + level_count[rest_book][tick]) % LEVEL_DEPTH;
          order_qty[rest_book][tick][slot] = 16'(remain);
          level_count[rest_book][tick]++;
          rpt.rested_quantity = 16'(remain);
        end else begin
          rpt.status = lobm_pkg::STATUS_FULL;
        end
      end
    end
    rpt.fill_units = (filled > 65535) ? 16'hFFFF : filled[15:0];
    rpt.fill_value = (value > 24'hFFFFFF) ? 24'hFFFFFF : value[23:0];
    for (lv = NUM_LEVELS - 1; lv >= 0; lv--) begin
      if (level_count[BOOK_BID][lv] > 0) begin
        rpt.best_bid = 8'(lv);
        rpt.bid_present = 1'b1;
        break;
      end
    end
    for (lv = 0; lv < NUM_LEVELS; lv++) begin
      if (level_count[BOOK_ASK][lv] > 0) begin
        rpt.best_ask = 8'(lv);
        rpt.ask_present = 1'b1;
        break;
      end
    end
    return rpt;
  endfunction

  // Offer one order, hold it until accepted, then idle a random gap
  task automatic send_order(logic [1:0] kind, logic side, logic [15:0] qty,
                            logic [7:0] tick);
    int gap;
    in_valid_i <= 1'b1;
    kind_i <= kind;
    side_i <= side;
    quantity_i <= qty;
    price_tick_i <= tick;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_reports = {expected_reports, match_order(kind, side, qty, tick)};
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_ready_i <= ($urandom_range(0, 9) < 7) ? 1'b1 : ($urandom_range(0, 9) == 0);
    end
  end

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // Compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    fill_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result transaction", $time);
        error_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("status", want.status, status_o);
        check_field("fill_units", want.fill_units, fill_units_o);
        check_field("fill_value", want.fill_value, fill_value_o);
        check_field("rested_quantity", want.rested_quantity, rested_quantity_o);
        check_field("best_bid", want.best_bid, best_bid_o);
        check_field("bid_present", want.bid_present, bid_present_o);
        check_field("best_ask", want.best_ask, best_ask_o);
        check_field("ask_present", want.ask_present, ask_present_o);
      end
    end
  end

  task automatic reset_book;
    foreach (level_count[b, l]) begin
      level_count[b][l] = 0;
      level_head[b][l] = 0;
    end
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  endtask

  task automatic test_extremes;
    send_order(lobm_pkg::KIND_MARKET, lobm_pkg::SIDE_BUY, 16'd100, 8'd0);   // empty book
    send_order(lobm_pkg::KIND_REST, lobm_pkg::SIDE_BUY, 16'hFFFF, 8'd0);
    send_order(lobm_pkg::KIND_REST, lobm_pkg::SIDE_SELL, 16'hFFFF, 8'd255);
    send_order(lobm_pkg::KIND_LIMIT, lobm_pkg::SIDE_BUY, 16'd1, 8'd255);
    send_order(lobm_pkg::KIND_MARKET, lobm_pkg::SIDE_SELL, 16'hFFFF, 8'd255);
    send_order(lobm_pkg::KIND_UNUSED, lobm_pkg::SIDE_SELL, 16'd5, 8'd7);
    send_order(lobm_pkg::KIND_LIMIT, lobm_pkg::SIDE_BUY, 16'd0, 8'd9);
    send_order(lobm_pkg::KIND_MARKET, lobm_pkg::SIDE_BUY, 16'hFFFF, 8'd0);  // sweep all asks
    send_order(lobm_pkg::KIND_REST, lobm_pkg::SIDE_BUY, 16'd40, 8'd20);
    send_order(lobm_pkg::KIND_REST, lobm_pkg::SIDE_SELL, 16'd30, 8'd10);    // crossed book
    send_order(lobm_pkg::KIND_LIMIT, lobm_pkg::SIDE_SELL, 16'd25, 8'd20);   // partial, no remainder
    send_order(lobm_pkg::KIND_LIMIT, lobm_pkg::SIDE_BUY, 16'd50, 8'd10);    // partial, rest remainder
    send_order(lobm_pkg::KIND_LIMIT, lobm_pkg::SIDE_SELL, 16'd20, 8'd5);    // completely filled
  endtask

  task automatic test_level_full;
    repeat (17) send_order(lobm_pkg::KIND_REST, lobm_pkg::SIDE_SELL, 16'd3, 8'd200);
    send_order(lobm_pkg::KIND_LIMIT, lobm_pkg::SIDE_SELL, 16'd9, 8'd200);
    send_order(lobm_pkg::KIND_LIMIT, lobm_pkg::SIDE_BUY, 16'd200, 8'd200);
  endtask

  task automatic test_random_orders(int count);
    logic [1:0]  kind;
    logic        side;
    logic [15:0] qty;
    logic [7:0]  tick;
    int          pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      kind = (pick < 10) ? lobm_pkg::KIND_MARKET : (pick < 60) ? lobm_pkg::KIND_LIMIT :
             (pick < 95) ? lobm_pkg::KIND_REST : lobm_pkg::KIND_UNUSED;
      side = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      qty = (pick < 80) ? 16'($urandom_range(1, 60)) :
            (pick < 95) ? 16'($urandom_range(0, 16'hFFFF)) :
            (pick < 98) ? 16'd0 : 16'hFFFF;
      // Keep most prices in a narrow band around the spread
      tick = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(120, 136)) :
             8'($urandom_range(0, 255));
      send_order(kind, side, qty, tick);
    end
  endtask

  task automatic test_output_stall;
    hold_off_cycles = 400;
    test_random_orders(20);
  endtask

  task automatic wait_drain;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  initial begin
    reset_book();
    test_extremes();
    test_level_full();
    test_random_orders(900);
    test_output_stall();
    test_random_orders(900);
    in_valid_i <= 1'b0;
    wait_drain();
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* sim.f */
design/lobm_pkg.sv
design/lobm_side_mem.sv
design/lobm_fill_unit.sv
design/limit_order_book_matcher_top.sv
design/lobm_checker.sv
test/limit_order_book_matcher_top_test.sv
